// ----- rtl/dq_pkg.sv -----
package dq_pkg;

	localparam int CMD_W      = 4;
	localparam int VALUE_W    = 32;
	localparam int AMOUNT_W   = 11;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 11;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 80;
	localparam int M_PAD_W    = M_TDATA_W - (2 * VALUE_W + 1 + COUNT_W);
	localparam int S_PAD_W    = S_TDATA_W - (VALUE_W + AMOUNT_W);

	typedef enum logic [CMD_W-1:0] {
		CMD_QUERY       = 4'd0,
		CMD_PUT_FRONT   = 4'd1,
		CMD_PUT_BACK    = 4'd2,
		CMD_POP_FRONT   = 4'd3,
		CMD_POP_BACK    = 4'd4,
		CMD_PRUNE_FRONT = 4'd5,
		CMD_PRUNE_BACK  = 4'd6,
		CMD_KEEP_FRONT  = 4'd7,
		CMD_KEEP_BACK   = 4'd8,
		CMD_CLEAR       = 4'd9
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_AMOUNT = 2'd3
	} status_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

// ----- rtl/double_ended_queue_top.sv -----
// Bounded double-ended queue of DEPTH entries of DATA_WIDTH bits in one
// synchronous memory with two read ports. Each command on the slave stream
// (tuser = command, tdata = data_value then amount) yields exactly one result
// on the master stream (tuser = status, tdata = item_count, is_empty,
// front_value, back_value). When a command is accepted, the indices and
// count are updated, any put is written and both ends are read from the
// memory; the registered read data then moves into the output register as
// soon as that register is free. The block takes no new command while one
// is in flight. A failed command leaves the queue unchanged and reports
// its status. Values wider or narrower than DATA_WIDTH are truncated or
// zero-extended at the ports. There is no clearing pass after reset.
module double_ended_queue_top #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// data_value [31:0], amount [42:32], zero [47:43]
	input  logic [dq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// command [3:0]
	input  logic [dq_pkg::CMD_W-1:0]       s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// item_count [10:0], is_empty [11], front_value [43:12], back_value [75:44],
	// zero [79:76]
	output logic [dq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	// status [1:0]
	output logic [dq_pkg::STATUS_W-1:0]    m_axis_tuser
);
	import dq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                  accept;
	logic                  valid_s1;
	logic                  advance;
	mem_ctl_t              mem_ctl;
	logic [IW-1:0]         waddr;
	logic [IW-1:0]         front_addr;
	logic [IW-1:0]         back_addr;
	logic [DATA_WIDTH-1:0] front_data;
	logic [DATA_WIDTH-1:0] back_data;
	status_t               status;
	logic [CW-1:0]         count;
	logic                  empty_s1;
	logic [VALUE_W-1:0]    front_val;
	logic [VALUE_W-1:0]    back_val;
	logic [VALUE_W-1:0]    in_value;
	logic [AMOUNT_W-1:0]   in_amount;

	assign in_value      = s_axis_tdata[VALUE_W-1:0];
	assign in_amount     = s_axis_tdata[VALUE_W+AMOUNT_W-1:VALUE_W];
	assign s_axis_tready = !valid_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);

	dq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cmd        (s_axis_tuser),
		.amount     (in_amount),
		.mem_ctl    (mem_ctl),
		.waddr      (waddr),
		.front_addr (front_addr),
		.back_addr  (back_addr),
		.status     (status),
		.count      (count)
	);

	dq_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk        (clk),
		.ctl        (mem_ctl),
		.waddr      (waddr),
		.wdata      (DATA_WIDTH'(in_value)),
		.front_addr (front_addr),
		.back_addr  (back_addr),
		.front_data (front_data),
		.back_data  (back_data)
	);

	// Report zero at both ends of an empty queue.
	assign empty_s1  = (count == '0);
	assign front_val = empty_s1 ? '0 : VALUE_W'(front_data);
	assign back_val  = empty_s1 ? '0 : VALUE_W'(back_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_axis_tuser <= status;
			m_axis_tdata <= {{M_PAD_W{1'b0}}, back_val, front_val, empty_s1,
				COUNT_W'(count)};
		end
	end

endmodule

// ----- rtl/dq_store.sv -----
module dq_store #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  dq_pkg::mem_ctl_t             ctl,
	input  logic [$clog2(DEPTH)-1:0]     waddr,
	input  logic [DATA_WIDTH-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0]     front_addr,
	input  logic [$clog2(DEPTH)-1:0]     back_addr,
	output logic [DATA_WIDTH-1:0]        front_data,
	output logic [DATA_WIDTH-1:0]        back_data
);
	import dq_pkg::*;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] front_rd_q;
	logic [DATA_WIDTH-1:0] back_rd_q;
	logic [DATA_WIDTH-1:0] wdata_q;
	logic                  fwd_front_q;
	logic                  fwd_back_q;

	// Read returns old contents; bypass the value written in the same cycle.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			front_rd_q  <= mem[front_addr];
			back_rd_q   <= mem[back_addr];
			fwd_front_q <= ctl.wr_en && (waddr == front_addr);
			fwd_back_q  <= ctl.wr_en && (waddr == back_addr);
			wdata_q     <= wdata;
		end
	end

	assign front_data = fwd_front_q ? wdata_q : front_rd_q;
	assign back_data  = fwd_back_q  ? wdata_q : back_rd_q;

endmodule

// ----- rtl/dq_ctrl.sv -----
module dq_ctrl #(
	parameter int DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [dq_pkg::CMD_W-1:0]          cmd,
	input  logic [dq_pkg::AMOUNT_W-1:0]       amount,
	output dq_pkg::mem_ctl_t                  mem_ctl,
	output logic [$clog2(DEPTH)-1:0]          waddr,
	output logic [$clog2(DEPTH)-1:0]          front_addr,
	output logic [$clog2(DEPTH)-1:0]          back_addr,
	output dq_pkg::status_t                   status,
	output logic [$clog2(DEPTH+1)-1:0]        count
);
	import dq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (CW > AMOUNT_W) ? CW : AMOUNT_W;

	function automatic logic [IW-1:0] idx_add(logic [IW-1:0] base, logic [CW-1:0] n);
		logic [CW-1:0] nm;
		logic [IW:0]   s;
		nm = (n == CW'(DEPTH)) ? '0 : n;
		s  = (IW+1)'(base) + (IW+1)'(nm);
		if (s >= (IW+1)'(DEPTH)) begin
			s = s - (IW+1)'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	function automatic logic [IW-1:0] idx_sub(logic [IW-1:0] base, logic [CW-1:0] n);
		logic [CW-1:0] nm;
		logic [IW:0]   s;
		nm = (n == CW'(DEPTH)) ? '0 : n;
		s  = (IW+1)'(base) + (IW+1)'(DEPTH) - (IW+1)'(nm);
		if (s >= (IW+1)'(DEPTH)) begin
			s = s - (IW+1)'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [CW-1:0] count_q;
	status_t       status_q;

	logic [IW-1:0] head_nx;
	logic [IW-1:0] tail_nx;
	logic [CW-1:0] count_nx;
	status_t       status_nx;
	logic [CW-1:0] drop_n;
	logic          do_front;
	logic          do_back;
	logic          put_en;
	logic          full;
	logic          empty;
	logic          amt_over;
	logic [IW-1:0] head_dec;
	cmd_t          cmd_c;

	assign cmd_c    = cmd_t'(cmd);
	assign full     = (count_q >= CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign amt_over = (AW'(amount) > AW'(count_q));
	assign head_dec = idx_sub(head_q, CW'(1));

	always_comb begin
		status_nx = ST_OK;
		drop_n    = '0;
		do_front  = 1'b0;
		do_back   = 1'b0;
		put_en    = 1'b0;
		waddr     = tail_q;
		head_nx   = head_q;
		tail_nx   = tail_q;
		count_nx  = count_q;
		unique case (cmd_c)
			CMD_PUT_FRONT: begin
				if (full) begin
					status_nx = ST_FULL;
				end else begin
					put_en   = 1'b1;
					waddr    = head_dec;
					head_nx  = head_dec;
					count_nx = count_q + CW'(1);
				end
			end
			CMD_PUT_BACK: begin
				if (full) begin
					status_nx = ST_FULL;
				end else begin
					put_en   = 1'b1;
					tail_nx  = idx_add(tail_q, CW'(1));
					count_nx = count_q + CW'(1);
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (empty) begin
					status_nx = ST_EMPTY;
				end else begin
					drop_n   = CW'(1);
					do_front = (cmd_c == CMD_POP_FRONT);
					do_back  = (cmd_c == CMD_POP_BACK);
				end
			end
			CMD_PRUNE_FRONT, CMD_PRUNE_BACK: begin
				if (amt_over) begin
					status_nx = ST_AMOUNT;
				end else begin
					drop_n   = CW'(amount);
					do_front = (cmd_c == CMD_PRUNE_FRONT);
					do_back  = (cmd_c == CMD_PRUNE_BACK);
				end
			end
			CMD_KEEP_FRONT, CMD_KEEP_BACK: begin
				if (amt_over) begin
					status_nx = ST_AMOUNT;
				end else begin
					drop_n   = count_q - CW'(amount);
					do_back  = (cmd_c == CMD_KEEP_FRONT);
					do_front = (cmd_c == CMD_KEEP_BACK);
				end
			end
			CMD_CLEAR: begin
				head_nx  = '0;
				tail_nx  = '0;
				count_nx = '0;
			end
			default: begin
			end
		endcase
		// Removal from either end moves one index and shrinks the count.
		if (do_front) begin
			head_nx  = idx_add(head_q, drop_n);
			count_nx = count_q - drop_n;
		end
		if (do_back) begin
			tail_nx  = idx_sub(tail_q, drop_n);
			count_nx = count_q - drop_n;
		end
	end

	assign mem_ctl.wr_en = accept && put_en;
	assign mem_ctl.rd_en = accept;
	assign front_addr    = head_nx;
	assign back_addr     = idx_sub(tail_nx, CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			status_q <= ST_OK;
		end else if (accept) begin
			head_q   <= head_nx;
			tail_q   <= tail_nx;
			count_q  <= count_nx;
			status_q <= status_nx;
		end
	end

	assign status = status_q;
	assign count  = count_q;

endmodule

// ----- rtl/dq_checker.sv -----
module dq_checker #(
	parameter int DEPTH = 1024
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [dq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	input logic [dq_pkg::STATUS_W-1:0]    m_axis_tuser
);
	import dq_pkg::*;

	// One command in flight: no transfer on the cycle after a transfer.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("command taken while previous one in flight");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[11] == (m_axis_tdata[10:0] == '0)))
		else $error("empty flag disagrees with item count");

	a_empty_values: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[11] |-> (m_axis_tdata[75:12] == '0))
		else $error("empty queue shows non-zero end values");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_FULL) |->
			(m_axis_tdata[10:0] == COUNT_W'(DEPTH)))
		else $error("full status with queue not full");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind double_ended_queue_top dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
